[sv/vision_blob_frame_parser_macros.svh]
// Assertion macros for the blob frame parser.
`ifndef VISION_BLOB_FRAME_PARSER_MACROS_SVH
`define VISION_BLOB_FRAME_PARSER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define VBFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vbfp assertion failed");

// Check that cons holds in the cycle after ante.
`define VBFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vbfp assertion failed");

`endif

[sv/vbfp_pkg.sv]
package vbfp_pkg;

   // Objects per channel and frame that are emitted (range 1 to 4).
   localparam int MaxObjects = 4;

   localparam logic [7:0] CharDollar = 8'd36;
   localparam logic [7:0] CharHash   = 8'd35;
   localparam logic [7:0] CharAmp    = 8'd38;
   localparam logic [7:0] CharCaret  = 8'd94;
   localparam logic [7:0] CharColon  = 8'd58;

   localparam logic KindRecord = 1'b0;
   localparam logic KindFrame  = 1'b1;

   localparam logic [1:0] TagUnknown = 2'd3;
   localparam logic [1:0] LastField  = 2'd3;
   localparam logic [2:0] CountMax   = 3'd7;

   typedef enum logic [2:0] {
      PhHunt,
      PhFnum,
      PhTag,
      PhField,
      PhSep
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] channel;
      logic [1:0] index;
      logic [7:0] area;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] axis;
      logic [2:0] count_a;
      logic [2:0] count_b;
      logic [2:0] count_c;
   } result_type;

   typedef struct packed {
      phase_type       phase;
      logic [7:0]      hex_accum;
      logic [1:0]      digit_count;
      logic [1:0]      field_number;
      logic [2:0][7:0] field_store;
      logic [1:0]      record_tag;
      logic [2:0][2:0] channel_counts;
   } state_type;

   typedef struct packed {
      state_type  s;
      logic       again;
      logic       push;
      result_type r;
   } step_type;

   // Frame-complete result carrying the three channel counts.
   function automatic result_type close_result(logic [2:0][2:0] counts);
      result_type r;
      r         = '0;
      r.kind    = KindFrame;
      r.count_a = counts[0];
      r.count_b = counts[1];
      r.count_c = counts[2];
      return r;
   endfunction

   // End of one hex field: store it, or finish the record on the axis field; a record past MaxObjects closes the frame.
   function automatic step_type field_done(step_type t_in);
      step_type   t;
      logic [7:0] v;
      logic [1:0] tag;
      logic [2:0] num;
      t = t_in;
      v = t.s.hex_accum;
      t.s.hex_accum = '0;
      t.s.digit_count = '0;
      if (t.s.field_number != LastField) begin
         t.s.field_store[t.s.field_number] = v;
         t.s.phase = PhSep;
      end else begin
         t.s.phase = PhTag;
         tag = t.s.record_tag;
         if (tag != TagUnknown) begin
            num = t.s.channel_counts[tag];
            if (num != CountMax) begin
               t.s.channel_counts[tag] = num + 3'd1;
            end
            if (num < 3'(MaxObjects)) begin
               t.push      = 1'b1;
               t.r         = '0;
               t.r.kind    = KindRecord;
               t.r.channel = tag;
               t.r.index   = num[1:0];
               t.r.area    = t.s.field_store[0];
               t.r.pos_x   = t.s.field_store[1];
               t.r.pos_y   = t.s.field_store[2];
               t.r.axis    = v;
            end else begin
               t.push = 1'b1;
               t.r = close_result(t.s.channel_counts);
               t.s.channel_counts = '0;
               t.s.phase = PhHunt;
            end
         end
      end
      return t;
   endfunction

   // One pass of the parser over one byte in the current phase.
   function automatic step_type parse_step(state_type s, logic [7:0] b);
      step_type   t;
      logic       hv;
      logic [3:0] hn;
      logic       sp;
      logic [1:0] dn;
      t       = '0;
      t.s     = s;
      hv      = 1'b1;
      hn      = b[3:0];
      if (b >= 8'd48 && b <= 8'd57) begin
         hn = b[3:0];
      end else if ((b >= 8'd97 && b <= 8'd102) || (b >= 8'd65 && b <= 8'd70)) begin
         hn = b[3:0] + 4'd9;
      end else begin
         hv = 1'b0;
      end
      sp = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
      dn = s.digit_count + 2'd1;
      case (s.phase)
         PhHunt: begin
            if (b == CharDollar) begin
               t.s.phase = PhFnum;
               t.s.digit_count = '0;
               t.s.hex_accum = '0;
            end
         end
         PhFnum: begin
            if (s.digit_count == 2'd0 && sp) begin
               t.s.phase = PhFnum;
            end else if (hv) begin
               t.s.digit_count = dn;
               if (dn >= 2'd2) begin
                  t.s.phase = PhTag;
                  t.s.digit_count = '0;
               end
            end else begin
               t.s.phase = PhTag;
               t.s.digit_count = '0;
               t.again = 1'b1;
            end
         end
         PhTag: begin
            if (b == CharDollar) begin
               t.push = 1'b1;
               t.r = close_result(s.channel_counts);
               t.s.channel_counts = '0;
               t.s.phase = PhFnum;
               t.s.digit_count = '0;
            end else begin
               if (b == CharHash) begin
                  t.s.record_tag = 2'd0;
               end else if (b == CharAmp) begin
                  t.s.record_tag = 2'd1;
               end else if (b == CharCaret) begin
                  t.s.record_tag = 2'd2;
               end else begin
                  t.s.record_tag = TagUnknown;
               end
               t.s.field_number = '0;
               t.s.digit_count = '0;
               t.s.hex_accum = '0;
               t.s.phase = PhField;
            end
         end
         PhField: begin
            if (s.digit_count == 2'd0 && sp) begin
               t.s.phase = PhField;
            end else if (hv) begin
               t.s.hex_accum = {s.hex_accum[3:0], hn};
               t.s.digit_count = dn;
               if (dn >= 2'd2) begin
                  t = field_done(t);
               end
            end else if (s.digit_count == 2'd0) begin
               t.s.phase = PhHunt;
               t.again = 1'b1;
            end else begin
               t = field_done(t);
               t.again = 1'b1;
            end
         end
         PhSep: begin
            if (b == CharColon) begin
               t.s.field_number = s.field_number + 2'd1;
               t.s.digit_count = '0;
               t.s.hex_accum = '0;
               t.s.phase = PhField;
            end else begin
               t.s.phase = PhHunt;
               t.again = 1'b1;
            end
         end
         default: begin
            t.s.phase = PhHunt;
         end
      endcase
      return t;
   endfunction

endpackage

[sv/vbfp_if.sv]
// Byte input channel.
interface vbfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface vbfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] channel;
   logic [1:0] index;
   logic [7:0] area;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic [7:0] axis;
   logic [2:0] count_a;
   logic [2:0] count_b;
   logic [2:0] count_c;

   modport source (output valid, output kind, output channel, output index,
                   output area, output pos_x, output pos_y, output axis,
                   output count_a, output count_b, output count_c, input ready);
   modport sink (input valid, input kind, input channel, input index,
                 input area, input pos_x, input pos_y, input axis,
                 input count_a, input count_b, input count_c, output ready);
endinterface

[sv/vbfp_out_buffer.sv]
module vbfp_out_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  vbfp_pkg::result_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vbfp_pkg::result_type out_item
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   vbfp_pkg::result_type out_item_ff, out_item_in;
   vbfp_pkg::result_type skid_item_ff, skid_item_in;
   logic                 take;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
   assign take      = out_valid_ff && out_ready;

   // Advance the skid into the output register, or park a new item.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            out_item_in = in_item;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff) begin
            out_item_in  = in_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = in_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

[sv/vision_blob_frame_parser.sv]
// channel  dir  handshake            payload
// req_ch   in   valid/ready          in_byte
// rsp_ch   out  valid/ready          kind, channel, index, area, pos_x, pos_y,
//                                    axis, count_a, count_b, count_c
//
// One byte is taken per cycle while req_ch is not stalled; its parser update
// finishes in the cycle it is accepted and its result, if any, is registered
// in the output buffer. A '$' ending a record's last field gives a second
// result, the frame close, which is held until the next byte is accepted.
// Synchronous reset returns the parser to hunting for the start of a frame.
// A two-entry output buffer (register plus skid) stalls req_ch only while full.
`include "vision_blob_frame_parser_macros.svh"

module vision_blob_frame_parser (
   input  logic      clock,
   input  logic      reset,
   vbfp_req_if.sink  req_ch,
   vbfp_rsp_if.source rsp_ch
);

   vbfp_pkg::state_type  state_ff, state_in;
   vbfp_pkg::result_type pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   vbfp_pkg::state_type  chain [5];
   vbfp_pkg::step_type   step [4];
   vbfp_pkg::result_type q0, q1, res_item;
   logic [1:0]           qn;
   logic                 active;
   logic                 accept;
   logic                 res_valid;
   logic                 buf_ready;
   vbfp_pkg::result_type out_item;

   assign accept       = req_ch.valid && buf_ready;
   assign req_ch.ready = buf_ready;

   // Run the byte through up to four parser passes, collecting results.
   always_comb begin
      chain[0] = state_ff;
      q0       = '0;
      q1       = '0;
      qn       = '0;
      active   = 1'b1;
      for (int k = 0; k < 4; k++) begin
         step[k] = vbfp_pkg::parse_step(chain[k], req_ch.in_byte);
         if (active) begin
            chain[k+1] = step[k].s;
            if (step[k].push) begin
               if (qn == 2'd0) begin
                  q0 = step[k].r;
                  qn = 2'd1;
               end else if (qn == 2'd1) begin
                  q1 = step[k].r;
                  qn = 2'd2;
               end
            end
            active = step[k].again;
         end else begin
            chain[k+1] = chain[k];
         end
      end
   end

   // Emit the pending result first, hold the second result of a byte.
   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      res_item      = q0;
      res_valid     = 1'b0;
      if (accept) begin
         state_in = chain[4];
         if (pend_valid_ff) begin
            res_item  = pend_ff;
            res_valid = 1'b1;
            if (qn != 2'd0) begin
               pend_in = q0;
            end else begin
               pend_valid_in = 1'b0;
            end
         end else if (qn != 2'd0) begin
            res_valid = 1'b1;
            if (qn == 2'd2) begin
               pend_in       = q1;
               pend_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= vbfp_pkg::PhHunt;
         state_ff.hex_accum      <= '0;
         state_ff.digit_count    <= '0;
         state_ff.field_number   <= '0;
         state_ff.record_tag     <= '0;
         state_ff.channel_counts <= '0;
         pend_valid_ff           <= 1'b0;
      end else begin
         state_ff.phase          <= state_in.phase;
         state_ff.hex_accum      <= state_in.hex_accum;
         state_ff.digit_count    <= state_in.digit_count;
         state_ff.field_number   <= state_in.field_number;
         state_ff.record_tag     <= state_in.record_tag;
         state_ff.channel_counts <= state_in.channel_counts;
         pend_valid_ff           <= pend_valid_in;
      end
      state_ff.field_store <= state_in.field_store;
      pend_ff              <= pend_in;
   end

   vbfp_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (buf_ready),
      .in_item   (res_item),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.kind    = out_item.kind;
   assign rsp_ch.channel = out_item.channel;
   assign rsp_ch.index   = out_item.index;
   assign rsp_ch.area    = out_item.area;
   assign rsp_ch.pos_x   = out_item.pos_x;
   assign rsp_ch.pos_y   = out_item.pos_y;
   assign rsp_ch.axis    = out_item.axis;
   assign rsp_ch.count_a = out_item.count_a;
   assign rsp_ch.count_b = out_item.count_b;
   assign rsp_ch.count_c = out_item.count_c;

   // A stalled input means a result is waiting at the output.
   `VBFP_ASSERT_NOW(a_stall_has_result, clock, reset, !req_ch.ready, rsp_ch.valid)
   // A held second result only follows a frame close by '$'.
   `VBFP_ASSERT_NOW(a_pend_after_close, clock, reset, pend_valid_ff,
                    state_ff.phase == vbfp_pkg::PhFnum)
   // A pending result drains on an accepted byte that makes no new result.
   `VBFP_ASSERT_NEXT(a_pend_drains, clock, reset, pend_valid_ff && accept && qn == 2'd0, !pend_valid_ff)

endmodule
